// File: design/rpmat_pkg.sv
// ----------------------------------------------------------------------------
// rpmat_pkg
// Shared types and constants for the motor RPM aging table.
// ----------------------------------------------------------------------------
package rpmat_pkg;

    localparam int RPM_W       = 32;
    localparam int AGE_W       = 8;
    localparam int MOTOR_W     = 4;
    localparam int MODE_W      = 3;
    localparam int CNT_OUT_W   = 4;
    localparam int MCOUNT_W    = 4;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 40;
    localparam int CFG_ADDR_W  = 2;
    localparam int CFG_DATA_W  = 8;

    localparam logic [AGE_W-1:0]    INVALID_AGE_RST = 8'd3;
    localparam logic [MCOUNT_W-1:0] MOTOR_COUNT_RST = 4'd4;

    typedef enum logic [MODE_W-1:0] {
        MODE_CLEAR  = 3'd0,
        MODE_SAMPLE = 3'd1,
        MODE_MISS   = 3'd2,
        MODE_QUERY  = 3'd3,
        MODE_AVG    = 3'd4
    } t_mode;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_BIDIR       = 2'd0,
        CFG_INVALID_AGE = 2'd1,
        CFG_MOTOR_COUNT = 2'd2
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ACCESS,
        S_WALK,
        S_EVAL,
        S_DIV,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load_in;
        logic access;
        logic walk_step;
        logic div_start;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic walk_last;
        logic want_div;
        logic div_done;
        logic out_free;
    } t_sts;

endpackage

// File: design/rpmat_div.sv
// ----------------------------------------------------------------------------
// rpmat_div
// Restoring divider, one quotient bit per cycle. Expects remainder-sized
// divisor (the walk count) and the wide RPM sum as dividend.
// ----------------------------------------------------------------------------
module rpmat_div #(
    parameter int DVD_W = 36,
    parameter int DVS_W = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    output logic             o_done,
    output logic [DVD_W-1:0] o_quotient
);

    localparam int CW = (DVD_W > 1) ? $clog2(DVD_W) : 1;

    logic             r_busy;
    logic [CW-1:0]    r_cnt;
    logic [DVD_W-1:0] r_quo;
    logic [DVS_W-1:0] r_rem;
    logic [DVS_W-1:0] r_dvs;

    logic [DVS_W:0]   shifted;
    logic [DVS_W:0]   diff;
    logic             ge;
    logic [DVS_W-1:0] n_rem;
    logic             last;

    always_comb begin
        shifted = {r_rem, r_quo[DVD_W-1]};
        diff    = shifted - {1'b0, r_dvs};
        ge      = (shifted >= {1'b0, r_dvs});
        n_rem   = ge ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
        last    = (r_cnt == CW'(DVD_W - 1));
    end

    assign o_done     = r_busy && last;
    assign o_quotient = r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (o_done) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cnt <= '0;
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_cnt <= r_cnt + CW'(1);
            r_rem <= n_rem;
            r_quo <= {r_quo[DVD_W-2:0], ge};
        end
    end

endmodule

// File: design/rpmat_dp.sv
// ----------------------------------------------------------------------------
// rpmat_dp
// Datapath: configuration registers, per-slot RPM and age stores, the slot
// walk that counts fresh slots and sums RPMs, the divider and the output
// register.
// ----------------------------------------------------------------------------
module rpmat_dp #(
    parameter int MOTOR_SLOTS = 8
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [rpmat_pkg::CFG_ADDR_W-1:0]      i_cfg_addr,
    input  logic [rpmat_pkg::CFG_DATA_W-1:0]      i_cfg_wdata,
    input  logic [rpmat_pkg::IN_TDATA_W-1:0]      i_s_tdata,
    input  logic [rpmat_pkg::MODE_W-1:0]          i_s_tuser,
    input  logic                                  i_m_tready,
    output logic                                  o_m_tvalid,
    output logic [rpmat_pkg::OUT_TDATA_W-1:0]     o_m_tdata,
    input  rpmat_pkg::t_cmd                       i_cmd,
    output rpmat_pkg::t_sts                       o_sts
);

    import rpmat_pkg::*;

    localparam int IW   = (MOTOR_SLOTS > 1) ? $clog2(MOTOR_SLOTS) : 1;
    localparam int CNTW = $clog2(MOTOR_SLOTS + 1);
    localparam int SW   = RPM_W + CNTW;

    // configuration
    logic                r_bidir;
    logic [AGE_W-1:0]    r_invalid;
    logic [MCOUNT_W-1:0] r_mcount;

    // slot stores
    logic [RPM_W-1:0] r_rpm_st [MOTOR_SLOTS];
    logic [AGE_W-1:0] r_age    [MOTOR_SLOTS];

    // request
    t_mode             r_mode;
    logic [MOTOR_W-1:0] r_motor;
    logic [RPM_W-1:0]  r_rpm;

    // per-request results and walk state
    logic              r_ok;
    logic [RPM_W-1:0]  r_result;
    logic [IW-1:0]     r_idx;
    logic [CNTW-1:0]   r_cnt;
    logic [CNTW-1:0]   r_n;
    logic [SW-1:0]     r_sum;

    // output register
    logic                   r_o_valid;
    logic [OUT_TDATA_W-1:0] r_o_data;

    logic              in_range;
    logic [IW-1:0]     sel;
    logic [IW-1:0]     rd_addr;
    logic [AGE_W-1:0]  rd_age;
    logic [RPM_W-1:0]  rd_rpm;
    logic              rd_fresh;
    logic              in_avg_set;
    logic              want_div;
    logic [SW-1:0]     quotient;
    logic              div_done;
    logic              ok_final;
    logic [RPM_W-1:0]  res_final;
    logic [CNT_OUT_W-1:0] fresh_out;
    logic              any_out;

    always_comb begin
        in_range   = ({1'b0, r_motor} < 5'(MOTOR_SLOTS));
        sel        = r_motor[IW-1:0];
        // single read port: the walk owns it while stepping
        rd_addr    = i_cmd.walk_step ? r_idx : sel;
        rd_age     = r_age[rd_addr];
        rd_rpm     = r_rpm_st[rd_addr];
        rd_fresh   = (rd_age < r_invalid);
        in_avg_set = (5'(r_idx) < 5'(r_mcount));
        want_div   = (r_mode == MODE_AVG) && r_bidir && (r_n != '0);
        ok_final   = (r_mode == MODE_AVG) ? want_div : r_ok;
        res_final  = ((r_mode == MODE_AVG) && want_div) ? quotient[RPM_W-1:0] : r_result;
        fresh_out  = (5'(r_cnt) > 5'd15) ? 4'd15 : 4'(r_cnt);
        any_out    = (r_cnt != '0);
    end

    assign o_sts.walk_last = (r_idx == IW'(MOTOR_SLOTS - 1));
    assign o_sts.want_div  = want_div;
    assign o_sts.div_done  = div_done;
    assign o_sts.out_free  = !r_o_valid || i_m_tready;

    assign o_m_tvalid = r_o_valid;
    assign o_m_tdata  = r_o_data;

    rpmat_div #(
        .DVD_W (SW),
        .DVS_W (CNTW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_sum),
        .i_divisor  (r_n),
        .o_done     (div_done),
        .o_quotient (quotient)
    );

    // configuration, stores and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bidir   <= 1'b0;
            r_invalid <= INVALID_AGE_RST;
            r_mcount  <= MOTOR_COUNT_RST;
            r_o_valid <= 1'b0;
            for (int s = 0; s < MOTOR_SLOTS; s++) begin
                r_rpm_st[s] <= '0;
                r_age[s]    <= INVALID_AGE_RST;
            end
        end else begin
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_addr))
                    CFG_BIDIR:       r_bidir   <= i_cfg_wdata[0];
                    CFG_INVALID_AGE: r_invalid <= i_cfg_wdata[AGE_W-1:0];
                    CFG_MOTOR_COUNT: r_mcount  <= i_cfg_wdata[MCOUNT_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.access) begin
                unique case (r_mode)
                    MODE_CLEAR: begin
                        for (int s = 0; s < MOTOR_SLOTS; s++) begin
                            r_rpm_st[s] <= '0;
                            r_age[s]    <= r_invalid;
                        end
                    end
                    MODE_SAMPLE: begin
                        if (in_range) begin
                            r_rpm_st[sel] <= r_rpm;
                            r_age[sel]    <= '0;
                        end
                    end
                    MODE_MISS: begin
                        // saturate at the stale threshold
                        if (in_range && rd_fresh) begin
                            r_age[sel] <= rd_age + AGE_W'(1);
                        end
                    end
                    default: ;
                endcase
            end
            if (i_cmd.out_load) begin
                r_o_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // request capture, walk and output data
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_mode  <= t_mode'(i_s_tuser);
            r_motor <= i_s_tdata[MOTOR_W-1:0];
            r_rpm   <= i_s_tdata[MOTOR_W +: RPM_W];
        end
        if (i_cmd.access) begin
            r_idx <= '0;
            r_cnt <= '0;
            r_n   <= '0;
            r_sum <= '0;
            unique case (r_mode)
                MODE_CLEAR: begin
                    r_ok     <= 1'b1;
                    r_result <= '0;
                end
                MODE_SAMPLE, MODE_MISS: begin
                    r_ok     <= in_range;
                    r_result <= '0;
                end
                MODE_QUERY: begin
                    r_ok     <= in_range && r_bidir && rd_fresh;
                    r_result <= (in_range && r_bidir && rd_fresh) ? rd_rpm : '0;
                end
                default: begin
                    r_ok     <= 1'b0;
                    r_result <= '0;
                end
            endcase
        end
        if (i_cmd.walk_step) begin
            r_idx <= r_idx + IW'(1);
            if (rd_fresh) begin
                r_cnt <= r_cnt + CNTW'(1);
                if (in_avg_set) begin
                    r_sum <= r_sum + SW'(rd_rpm);
                    r_n   <= r_n + CNTW'(1);
                end
            end
        end
        if (i_cmd.out_load) begin
            r_o_data <= {2'b00, any_out, fresh_out, res_final, ok_final};
        end
    end

endmodule

// File: design/rpmat_ctrl.sv
// ----------------------------------------------------------------------------
// rpmat_ctrl
// Sequencer: takes one request, runs the update, walks every slot, starts
// the divider for an average and hands the result to the output register.
// ----------------------------------------------------------------------------
module rpmat_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_s_tvalid,
    output logic            o_s_tready,
    input  rpmat_pkg::t_sts i_sts,
    output rpmat_pkg::t_cmd o_cmd
);

    import rpmat_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (i_s_tvalid) n_state = S_ACCESS;
            S_ACCESS: n_state = S_WALK;
            S_WALK:   if (i_sts.walk_last) n_state = S_EVAL;
            S_EVAL:   n_state = i_sts.want_div ? S_DIV : S_DONE;
            S_DIV:    if (i_sts.div_done) n_state = S_DONE;
            S_DONE:   if (i_sts.out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_s_tready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            S_IDLE: begin
                o_s_tready    = 1'b1;
                o_cmd.load_in = i_s_tvalid;
            end
            S_ACCESS: o_cmd.access    = 1'b1;
            S_WALK:   o_cmd.walk_step = 1'b1;
            S_EVAL:   o_cmd.div_start = i_sts.want_div;
            S_DIV:    ;
            S_DONE:   o_cmd.out_load  = i_sts.out_free;
            default:  ;
        endcase
    end

endmodule

// File: design/motor_rpm_aging_table.sv
// ----------------------------------------------------------------------------
// motor_rpm_aging_table
// Per-motor RPM table with saturating ages, fresh-slot count and average.
// ----------------------------------------------------------------------------
// Usage: a request enters on the s channel (tuser = mode, tdata = motor and
// rpm_in) and yields exactly one result on the m channel (ok, rpm_out,
// fresh_count, any_active). Configuration registers must be written through the
// cfg port while no request is in flight; the block itself does not enforce this.
// Sequence: a request is accepted in the idle state, then the block updates
// the table, walks the slots (one slot per cycle over the single store read
// port) and decides; a successful average then runs through the bit-serial
// divider. The result is then loaded into the output register when it is free.
// The output register frees the input side: the next request is accepted
// while a result still waits. If a result is still stalled when the next
// one is ready, the block holds it and stops accepting until m takes it.
// Reset clears all RPMs to zero, sets every age and invalid_age to 3,
// motor_count to 4 and bidir_enabled to 0; the block is ready at once.
// ----------------------------------------------------------------------------
module motor_rpm_aging_table #(
    parameter int MOTOR_SLOTS = 8
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [rpmat_pkg::CFG_ADDR_W-1:0]      i_cfg_addr,
    input  logic [rpmat_pkg::CFG_DATA_W-1:0]      i_cfg_wdata,
    input  logic                                  i_s_tvalid,
    output logic                                  o_s_tready,
    // [3:0] motor, [35:4] rpm_in, [39:36] zero
    input  logic [rpmat_pkg::IN_TDATA_W-1:0]      i_s_tdata,
    // [2:0] mode
    input  logic [rpmat_pkg::MODE_W-1:0]          i_s_tuser,
    output logic                                  o_m_tvalid,
    input  logic                                  i_m_tready,
    // [0] ok, [32:1] rpm_out, [36:33] fresh_count, [37] any_active, [39:38] zero
    output logic [rpmat_pkg::OUT_TDATA_W-1:0]     o_m_tdata
);

    import rpmat_pkg::*;

    t_cmd cmd;
    t_sts sts;

    rpmat_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    rpmat_dp #(
        .MOTOR_SLOTS (MOTOR_SLOTS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .i_m_tready  (i_m_tready),
        .o_m_tvalid  (o_m_tvalid),
        .o_m_tdata   (o_m_tdata),
        .i_cmd       (cmd),
        .o_sts       (sts)
    );

endmodule

// File: design/rpmat_chk.sv
// ----------------------------------------------------------------------------
// rpmat_chk
// Port-level checks for the motor RPM aging table, bound to the top level.
// ----------------------------------------------------------------------------
module rpmat_chk (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_s_tvalid,
    input logic                              o_s_tready,
    input logic                              o_m_tvalid,
    input logic                              i_m_tready,
    input logic [rpmat_pkg::OUT_TDATA_W-1:0] o_m_tdata
);

    // one request at a time: the block is busy right after taking one
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("request accepted while previous one still in work");

    // hold a stalled result
    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)))
        else $error("stalled result changed or dropped");

    a_any_matches_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[37] == (o_m_tdata[36:33] != 4'd0)))
        else $error("any_active disagrees with fresh_count");

    a_fail_zero_rpm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tdata[0]) |-> (o_m_tdata[32:1] == 32'd0))
        else $error("failed request carries nonzero rpm_out");

    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[39:38] == 2'b00))
        else $error("result padding bits not zero");

endmodule

bind motor_rpm_aging_table rpmat_chk u_rpmat_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the motor RPM aging table: directed and random
// requests on the stream input, a behavioral copy of the table predicting
// every result, and random stalls on both stream sides.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rpmat_pkg::*;

    localparam int SLOTS       = 8;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_WAIT  = 60;

    // modes the block does not define; they must be rejected
    localparam int MODE_RSVD_FIRST = 5;
    localparam int MODE_RSVD_LAST  = 7;

    typedef struct packed {
        logic                 ok;
        logic [RPM_W-1:0]     rpm;
        logic [CNT_OUT_W-1:0] fresh;
        logic                 active;
    } t_table_result;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_ADDR_W-1:0]  cfg_addr;
    logic [CFG_DATA_W-1:0]  cfg_wdata;
    logic                   s_valid;
    wire                    s_ready;
    logic [IN_TDATA_W-1:0]  s_data;   // [3:0] motor, [35:4] rpm_in, [39:36] zero
    logic [MODE_W-1:0]      s_user;   // [2:0] mode
    wire                    m_valid;
    logic                   m_ready;
    wire  [OUT_TDATA_W-1:0] m_data;   // [0] ok, [32:1] rpm_out, [36:33] fresh_count,
                                      // [37] any_active, [39:38] zero

    // behavioral copy of the table and its registers
    logic                   bidir_q;
    logic [AGE_W-1:0]       stale_age_q;
    logic [MCOUNT_W-1:0]    avg_count_q;
    logic [RPM_W-1:0]       rpm_tbl [SLOTS];
    logic [AGE_W-1:0]       age_tbl [SLOTS];

    t_table_result          expected_results[$];
    int                     mismatch_count;
    int                     cycle_count;
    logic                   tx_idle_en;
    logic                   rx_idle_en;
    int                     rx_hold;

    motor_rpm_aging_table #(.MOTOR_SLOTS(SLOTS)) dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_addr  (cfg_addr),
        .i_cfg_wdata (cfg_wdata),
        .i_s_tvalid  (s_valid),
        .o_s_tready  (s_ready),
        .i_s_tdata   (s_data),
        .i_s_tuser   (s_user),
        .o_m_tvalid  (m_valid),
        .i_m_tready  (m_ready),
        .o_m_tdata   (m_data)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 93)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    function automatic void clear_table();
        for (int s = 0; s < SLOTS; s++) begin
            rpm_tbl[s] = '0;
            age_tbl[s] = stale_age_q;
        end
    endfunction

    function automatic logic slot_fresh(int s);
        return age_tbl[s] < stale_age_q;
    endfunction

    // Update the table copy with one request and return what the block answers.
    function automatic t_table_result apply_request(logic [MODE_W-1:0] mode,
                                                    logic [MOTOR_W-1:0] motor,
                                                    logic [RPM_W-1:0] rpm);
        t_table_result r;
        logic          in_range;
        logic [63:0]   rpm_sum;
        int            n;
        int            lim;
        int            fresh_n;
        r        = '0;
        in_range = motor < SLOTS;
        rpm_sum  = '0;
        n        = 0;
        fresh_n  = 0;
        case (mode)
            MODE_CLEAR: begin
                clear_table();
                r.ok = 1'b1;
            end
            MODE_SAMPLE: begin
                if (in_range) begin
                    rpm_tbl[motor] = rpm;
                    age_tbl[motor] = '0;
                    r.ok = 1'b1;
                end
            end
            MODE_MISS: begin
                if (in_range) begin
                    if (slot_fresh(motor))
                        age_tbl[motor] = age_tbl[motor] + 1'b1;
                    r.ok = 1'b1;
                end
            end
            MODE_QUERY: begin
                if (in_range && bidir_q && slot_fresh(motor)) begin
                    r.rpm = rpm_tbl[motor];
                    r.ok  = 1'b1;
                end
            end
            MODE_AVG: begin
                if (bidir_q) begin
                    lim = (avg_count_q < SLOTS) ? int'(avg_count_q) : SLOTS;
                    for (int s = 0; s < lim; s++) begin
                        if (slot_fresh(s)) begin
                            rpm_sum += rpm_tbl[s];
                            n++;
                        end
                    end
                    if (n != 0) begin
                        r.rpm = RPM_W'(rpm_sum / n);
                        r.ok  = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        for (int s = 0; s < SLOTS; s++)
            if (slot_fresh(s))
                fresh_n++;
        r.fresh  = (fresh_n > 15) ? 4'd15 : CNT_OUT_W'(fresh_n);
        r.active = fresh_n != 0;
        return r;
    endfunction

    function automatic void report_failure(string what, t_table_result want,
                                           t_table_result got);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $write("%0t %s: expected ok=%0b rpm=%08h fresh=%0d active=%0b, ",
                   $realtime, what, want.ok, want.rpm, want.fresh, want.active);
            $display("got ok=%0b rpm=%08h fresh=%0d active=%0b",
                     got.ok, got.rpm, got.fresh, got.active);
        end
    endfunction

    // result checker
    always @(posedge clk) begin
        t_table_result got;
        t_table_result want;
        if (rst_n && m_valid && m_ready) begin
            got.ok     = m_data[0];
            got.rpm    = m_data[32:1];
            got.fresh  = m_data[36:33];
            got.active = m_data[37];
            if (expected_results.size() == 0) begin
                report_failure("result with no request pending", '0, got);
            end else begin
                want = expected_results.pop_front();
                if (got.ok !== want.ok || got.rpm !== want.rpm ||
                    got.fresh !== want.fresh || got.active !== want.active)
                    report_failure("result mismatch", want, got);
            end
        end
    end

    // result side back-pressure
    always @(negedge clk) begin
        if (!rx_idle_en) begin
            m_ready <= 1'b1;
        end else if (rx_hold != 0) begin
            rx_hold--;
            m_ready <= 1'b0;
        end else begin
            rx_hold = pick_gap();
            if (rx_hold == 0) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b0;
                rx_hold--;
            end
        end
    end

    task automatic send_request(logic [MODE_W-1:0] mode, logic [MOTOR_W-1:0] motor,
                                logic [RPM_W-1:0] rpm);
        int gap;
        gap = tx_idle_en ? pick_gap() : 0;
        @(negedge clk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_valid <= 1'b1;
        s_user  <= mode;
        s_data  <= {4'b0, rpm, motor};
        do @(posedge clk); while (!s_ready);
        expected_results.push_back(apply_request(mode, motor, rpm));
    endtask

    // hold the request side idle until every pending result has been taken
    task automatic drain();
        @(negedge clk);
        s_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            CFG_BIDIR:       bidir_q     = value[0];
            CFG_INVALID_AGE: stale_age_q = value;
            CFG_MOTOR_COUNT: avg_count_q = value[MCOUNT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic test_reset_state();
        send_request(MODE_QUERY, 4'd0, '0);
        send_request(MODE_AVG, 4'd0, '0);
        send_request(MODE_MISS, 4'd0, '0);
        drain();
        write_reg(CFG_BIDIR, 8'd1);
        send_request(MODE_QUERY, 4'd3, '0);
        send_request(MODE_AVG, 4'd0, '0);
    endtask

    task automatic test_operations();
        // four full-scale samples: the average must not wrap
        for (int m = 0; m < 4; m++)
            send_request(MODE_SAMPLE, MOTOR_W'(m), 32'hFFFF_FFFF);
        send_request(MODE_AVG, 4'd0, '0);
        send_request(MODE_SAMPLE, 4'd7, 32'h0);
        send_request(MODE_SAMPLE, 4'd8, 32'h1234_5678);
        send_request(MODE_SAMPLE, 4'd15, 32'h5A5A_5A5A);
        send_request(MODE_QUERY, 4'd7, '0);
        send_request(MODE_QUERY, 4'd15, '0);
        send_request(MODE_MISS, 4'd15, '0);
        // age slot 0 past the threshold, then once more to check it saturates
        repeat (4) send_request(MODE_MISS, 4'd0, '0);
        send_request(MODE_QUERY, 4'd0, '0);
        send_request(MODE_QUERY, 4'd1, '0);
        send_request(MODE_AVG, 4'd0, '0);
        for (int m = MODE_RSVD_FIRST; m <= MODE_RSVD_LAST; m++)
            send_request(MODE_W'(m), 4'd1, 32'hA5A5_A5A5);
        send_request(MODE_CLEAR, 4'd0, '0);
        send_request(MODE_QUERY, 4'd1, '0);
        send_request(MODE_AVG, 4'd0, '0);
    endtask

    task automatic test_config_extremes();
        // zero threshold: nothing is ever fresh
        drain();
        write_reg(CFG_INVALID_AGE, 8'd0);
        send_request(MODE_SAMPLE, 4'd2, 32'hDEAD_BEEF);
        send_request(MODE_QUERY, 4'd2, '0);
        send_request(MODE_MISS, 4'd2, '0);
        send_request(MODE_AVG, 4'd0, '0);
        send_request(MODE_CLEAR, 4'd0, '0);
        // widest threshold, average over all slots and beyond
        drain();
        write_reg(CFG_INVALID_AGE, 8'd255);
        write_reg(CFG_MOTOR_COUNT, 8'd8);
        for (int m = 0; m < SLOTS; m++)
            send_request(MODE_SAMPLE, MOTOR_W'(m), $urandom);
        send_request(MODE_AVG, 4'd0, '0);
        drain();
        write_reg(CFG_MOTOR_COUNT, 8'd0);
        send_request(MODE_AVG, 4'd0, '0);
        drain();
        write_reg(CFG_MOTOR_COUNT, 8'd15);
        send_request(MODE_AVG, 4'd0, '0);
        drain();
        write_reg(CFG_MOTOR_COUNT, 8'd1);
        send_request(MODE_AVG, 4'd0, '0);
        // raising the threshold revives a stale slot
        drain();
        write_reg(CFG_INVALID_AGE, 8'd1);
        send_request(MODE_SAMPLE, 4'd5, 32'h0BAD_F00D);
        send_request(MODE_MISS, 4'd5, '0);
        send_request(MODE_QUERY, 4'd5, '0);
        drain();
        write_reg(CFG_INVALID_AGE, 8'd4);
        write_reg(CFG_MOTOR_COUNT, 8'd6);
        send_request(MODE_QUERY, 4'd5, '0);
        send_request(MODE_AVG, 4'd0, '0);
        drain();
        write_reg(CFG_BIDIR, 8'd0);
        send_request(MODE_QUERY, 4'd5, '0);
        send_request(MODE_AVG, 4'd0, '0);
        drain();
        write_reg(CFG_BIDIR, 8'd1);
    endtask

    task automatic test_random_traffic(int phases, int per_phase);
        int                  r;
        logic [MODE_W-1:0]   mode;
        logic [MOTOR_W-1:0]  motor;
        logic [RPM_W-1:0]    rpm;
        for (int p = 0; p < phases; p++) begin
            drain();
            write_reg(CFG_BIDIR, ($urandom_range(0, 9) != 0) ? 8'd1 : 8'd0);
            r = $urandom_range(0, 19);
            if (r == 0)
                write_reg(CFG_INVALID_AGE, 8'd0);
            else if (r == 1)
                write_reg(CFG_INVALID_AGE, 8'd255);
            else if (r == 2)
                write_reg(CFG_INVALID_AGE, CFG_DATA_W'($urandom_range(0, 255)));
            else
                write_reg(CFG_INVALID_AGE, CFG_DATA_W'($urandom_range(1, 6)));
            if ($urandom_range(0, 9) < 2)
                write_reg(CFG_MOTOR_COUNT, CFG_DATA_W'($urandom_range(9, 15)));
            else
                write_reg(CFG_MOTOR_COUNT, CFG_DATA_W'($urandom_range(0, 8)));
            r = $urandom_range(0, 3);
            tx_idle_en = r[0];
            rx_idle_en = r[1];
            for (int i = 0; i < per_phase; i++) begin
                r = $urandom_range(0, 99);
                if (r < 2)
                    mode = MODE_CLEAR;
                else if (r < 32)
                    mode = MODE_SAMPLE;
                else if (r < 55)
                    mode = MODE_MISS;
                else if (r < 77)
                    mode = MODE_QUERY;
                else if (r < 95)
                    mode = MODE_AVG;
                else
                    mode = MODE_W'($urandom_range(MODE_RSVD_FIRST, MODE_RSVD_LAST));
                if ($urandom_range(0, 9) == 0)
                    motor = MOTOR_W'($urandom_range(SLOTS, 15));
                else
                    motor = MOTOR_W'($urandom_range(0, SLOTS - 1));
                r = $urandom_range(0, 19);
                rpm = (r == 0) ? 32'h0 : (r == 1) ? 32'hFFFF_FFFF : $urandom;
                send_request(mode, motor, rpm);
            end
        end
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
    endtask

    initial begin
        clk            = 1'b0;
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_addr       = '0;
        cfg_wdata      = '0;
        s_valid        = 1'b0;
        s_user         = '0;
        s_data         = '0;
        m_ready        = 1'b0;
        rx_hold        = 0;
        tx_idle_en     = 1'b1;
        rx_idle_en     = 1'b1;
        mismatch_count = 0;
        cycle_count    = 0;
        bidir_q        = 1'b0;
        stale_age_q    = INVALID_AGE_RST;
        avg_count_q    = MOTOR_COUNT_RST;
        clear_table();
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_state();
        test_operations();
        test_config_extremes();
        test_random_traffic(17, 100);

        drain();
        repeat (DRAIN_WAIT) @(posedge clk);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule

// File: sim.f
design/rpmat_pkg.sv
design/rpmat_div.sv
design/rpmat_dp.sv
design/rpmat_ctrl.sv
design/motor_rpm_aging_table.sv
design/rpmat_chk.sv
tb/tb.sv
